// File: hdl/aald_pkg.sv
// Shared types and constants of the area average line downscaler.
package aald_pkg;

    localparam int SCAN_WIDTH_DEF        = 2048;
    localparam int MAX_DISPLAY_WIDTH_DEF = 2048;

    localparam int COORD_W = 12;   // scan column, crop bounds, display column
    localparam int DISP_W  = 13;   // display width, crop width
    localparam int PIX_W   = 8;
    localparam int ACC_W   = 16;
    localparam int ROW_W   = 16;
    localparam int SQ_W    = 25;   // square of a 13-bit width
    localparam int NUM_W   = 42;   // divider numerator
    localparam int DEN_W   = 26;   // divider denominator
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CROP_LEFT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_RIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH = 2'd2;

    localparam logic [COORD_W-1:0] CROP_LEFT_RST  = 12'd0;
    localparam logic [COORD_W-1:0] CROP_RIGHT_RST = 12'd2047;
    localparam logic [DISP_W-1:0]  DISP_WIDTH_RST = 13'd2048;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [ACC_W-1:0] ACC_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PX_MUL1,
        ST_PX_MUL2,
        ST_PX_DIV,
        ST_PX_WR,
        ST_RD_MUL,
        ST_RD_SUM,
        ST_RD_SAT,
        ST_RD_DIV,
        ST_RD_WR,
        ST_DONE
    } t_state;

endpackage

// File: hdl/area_average_line_downscaler.sv
// Area average line downscaler: raster pixels in, box-averaged display rows out.
//
// Scan pixels of the crop window are spread over two display columns and two
// display rows into a double-banked accumulator RAM (2*MAX_DISPLAY_WIDTH words,
// one read-modify-write at a time). Every request gives exactly one response.
// A pixel outside the crop or of value zero goes straight to its response; a
// pixel inside takes four shares, each a two-stage multiply, a bit-serial
// division by D*D and a RAM read and write. A readout multiplies, adds the
// rounding term, checks for saturation and runs the same divider. After reset
// and after every write to a used configuration index the block clears the
// RAM, one word a cycle, and takes no request meanwhile.
module area_average_line_downscaler
    import aald_pkg::*;
#(
    parameter int SCAN_WIDTH        = SCAN_WIDTH_DEF,
    parameter int MAX_DISPLAY_WIDTH = MAX_DISPLAY_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DISP_W-1:0]    i_cfg_data,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // [7:0] pixel, [19:8] display_col, [23:20] 0
    input  logic                 s_axis_tlast,   // line_end
    input  logic                 s_axis_tuser,   // operation
    // response stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // [7:0] display_pixel, [23:8] display_row
    output logic                 m_axis_tuser    // row_ready
);

    localparam int DEPTH = 2 * MAX_DISPLAY_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SCW   = $clog2(SCAN_WIDTH + 1);

    t_state r_state, n_state;

    // configuration and derived sizes
    logic [COORD_W-1:0] r_crop_left, r_crop_right;
    logic [DISP_W-1:0]  r_disp_width;
    logic [DISP_W-1:0]  r_c, r_d;
    logic [SQ_W-1:0]    r_dd, r_cc;

    // frame state
    logic [SCW-1:0]     r_col;
    logic [COORD_W-1:0] r_t;        // display column of current scan column
    logic [COORD_W-1:0] r_r;        // i*D - t*C
    logic [COORD_W-1:0] r_rem;
    logic [ROW_W-1:0]   r_idx;
    logic               r_bank;
    logic               r_ready;

    // per-request work registers
    logic [PIX_W-1:0]   r_pix;
    logic [DISP_W-1:0]  r_wa, r_wb, r_wcur, r_wnext;
    logic [COORD_W-1:0] r_tq;
    logic               r_bank_cur;
    logic [1:0]         r_sh;
    logic [COORD_W-1:0] r_rd_col;
    logic [AW-1:0]      r_rd_addr;
    logic               r_show;
    logic [PIX_W-1:0]   r_out_pix;
    logic [20:0]        r_prod1;
    logic [40:0]        r_prod2;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [PIX_W-1:0]   r_q;
    logic [2:0]         r_cnt;
    logic               r_sat;
    logic [AW-1:0]      r_clr_cnt;

    logic               r_m_valid;
    logic [23:0]        r_m_data;
    logic               r_m_user;

    // RAM port
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [ACC_W-1:0]   ram_wdata, ram_rdata;

    aald_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // request fields
    logic               in_op, in_le;
    logic [PIX_W-1:0]   in_pix;
    logic [COORD_W-1:0] in_dcol;
    logic               s_acc, cfg_hit, m_load;

    assign in_op   = s_axis_tuser;
    assign in_le   = s_axis_tlast;
    assign in_pix  = s_axis_tdata[7:0];
    assign in_dcol = s_axis_tdata[19:8];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign cfg_hit       = i_cfg_valid && (i_cfg_index == CFG_CROP_LEFT ||
                           i_cfg_index == CFG_CROP_RIGHT || i_cfg_index == CFG_DISPLAY_WIDTH);
    assign m_load        = (r_state == ST_DONE) && (!r_m_valid || m_axis_tready);

    // weights of the current column and row
    logic [DISP_W-1:0]  col13, left13, i13, cmr, cmrem, wa_c, wcur_c;
    logic               in_win, read_ok;
    logic [DISP_W:0]    r_step, rem_step;

    assign col13   = DISP_W'(r_col);
    assign left13  = DISP_W'(r_crop_left);
    assign i13     = col13 - left13;
    assign in_win  = (col13 < DISP_W'(SCAN_WIDTH)) && (col13 >= left13) && (i13 < r_c);
    assign cmr     = r_c - DISP_W'(r_r);
    assign cmrem   = r_c - DISP_W'(r_rem);
    assign wa_c    = (cmr < r_d) ? cmr : r_d;
    assign wcur_c  = (cmrem < r_d) ? cmrem : r_d;
    assign r_step  = (DISP_W+1)'(r_r) + (DISP_W+1)'(r_d);
    assign rem_step = (DISP_W+1)'(r_rem) + (DISP_W+1)'(r_d);
    assign read_ok = r_ready && (DISP_W'(in_dcol) < r_d);

    // share selection
    logic [DISP_W-1:0]  wr_sel, wc_sel, sh_col;
    logic               sh_bank, sh_ok;
    logic [AW-1:0]      sh_addr;

    assign wr_sel  = r_sh[1] ? r_wnext : r_wcur;
    assign wc_sel  = r_sh[0] ? r_wb : r_wa;
    assign sh_col  = DISP_W'(r_tq) + DISP_W'(r_sh[0]);
    assign sh_bank = r_bank_cur ^ r_sh[1];
    assign sh_ok   = sh_col < r_d;
    assign sh_addr = (sh_bank ? AW'(MAX_DISPLAY_WIDTH) : AW'(0)) + AW'(sh_col);

    // divider step and saturating add
    logic [NUM_W-1:0]   dsh;
    logic               dge;
    logic [ACC_W:0]     acc_sum;

    assign dsh     = NUM_W'(r_den) << r_cnt;
    assign dge     = r_num >= dsh;
    assign acc_sum = (ACC_W+1)'(ram_rdata) + (ACC_W+1)'(r_q);

    // derived crop and display widths
    logic [COORD_W-1:0] right_eff;
    logic [DISP_W-1:0]  d_c;

    always_comb begin
        right_eff = (r_crop_right < r_crop_left) ? r_crop_left : r_crop_right;
        d_c = (r_disp_width == '0) ? DISP_W'(1) : r_disp_width;
        if (d_c > DISP_W'(MAX_DISPLAY_WIDTH)) begin
            d_c = DISP_W'(MAX_DISPLAY_WIDTH);
        end
        if (d_c > r_c) begin
            d_c = r_c;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == AW'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (in_op == OP_READ) begin
                        n_state = read_ok ? ST_RD_MUL : ST_DONE;
                    end else begin
                        n_state = (in_win && in_pix != '0) ? ST_PX_MUL1 : ST_DONE;
                    end
                end
            end
            ST_PX_MUL1: n_state = ST_PX_MUL2;
            ST_PX_MUL2: n_state = ST_PX_DIV;
            ST_PX_DIV: begin
                if (r_cnt == '0) n_state = ST_PX_WR;
            end
            ST_PX_WR:  n_state = (r_sh == 2'd3) ? ST_DONE : ST_PX_MUL1;
            ST_RD_MUL: n_state = ST_RD_SUM;
            ST_RD_SUM: n_state = ST_RD_SAT;
            ST_RD_SAT: n_state = ST_RD_DIV;
            ST_RD_DIV: begin
                if (r_cnt == '0) n_state = ST_RD_WR;
            end
            ST_RD_WR:  n_state = ST_DONE;
            ST_DONE: begin
                if (m_load) n_state = ST_IDLE;
            end
            default:   n_state = ST_CLEAR;
        endcase
        if (cfg_hit) n_state = ST_CLEAR;
    end

    // RAM control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_cnt;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = sh_addr;
        case (r_state)
            ST_CLEAR: ram_we = 1'b1;
            ST_IDLE: begin
                ram_re    = s_acc && (in_op == OP_READ) && read_ok;
                ram_raddr = (r_bank ? AW'(0) : AW'(MAX_DISPLAY_WIDTH)) + AW'(in_dcol);
            end
            ST_PX_MUL1: ram_re = 1'b1;
            ST_PX_WR: begin
                ram_we    = sh_ok;
                ram_waddr = sh_addr;
                ram_wdata = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
            end
            ST_RD_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_rd_addr;
            end
            default: ram_we = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_cnt    <= '0;
            r_crop_left  <= CROP_LEFT_RST;
            r_crop_right <= CROP_RIGHT_RST;
            r_disp_width <= DISP_WIDTH_RST;
            r_col        <= '0;
            r_t          <= '0;
            r_r          <= '0;
            r_rem        <= '0;
            r_idx        <= '0;
            r_bank       <= 1'b0;
            r_ready      <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_cnt <= r_clr_cnt + AW'(1);

            if (s_acc && in_op == OP_PIXEL) begin
                if (in_le) begin
                    r_col <= '0;
                    r_t   <= '0;
                    r_r   <= '0;
                    if (rem_step >= (DISP_W+1)'(r_c)) begin
                        r_ready <= 1'b1;
                        r_bank  <= ~r_bank;
                        r_idx   <= r_idx + ROW_W'(1);
                        r_rem   <= COORD_W'(rem_step - (DISP_W+1)'(r_c));
                    end else begin
                        r_rem   <= COORD_W'(rem_step);
                    end
                end else if (col13 < DISP_W'(SCAN_WIDTH)) begin
                    r_col <= r_col + SCW'(1);
                    if (col13 >= left13) begin
                        if (r_step >= (DISP_W+1)'(r_c)) begin
                            r_r <= COORD_W'(r_step - (DISP_W+1)'(r_c));
                            r_t <= r_t + COORD_W'(1);
                        end else begin
                            r_r <= COORD_W'(r_step);
                        end
                    end
                end
            end
            if (r_state == ST_RD_WR && DISP_W'(r_rd_col) == r_d - DISP_W'(1)) begin
                r_ready <= 1'b0;
            end

            if (m_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (cfg_hit) begin
                case (i_cfg_index)
                    CFG_CROP_LEFT:  r_crop_left  <= i_cfg_data[COORD_W-1:0];
                    CFG_CROP_RIGHT: r_crop_right <= i_cfg_data[COORD_W-1:0];
                    default:        r_disp_width <= i_cfg_data;
                endcase
                r_clr_cnt <= '0;
                r_col     <= '0;
                r_t       <= '0;
                r_r       <= '0;
                r_rem     <= '0;
                r_idx     <= '0;
                r_bank    <= 1'b0;
                r_ready   <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_c  <= DISP_W'(right_eff - r_crop_left) + DISP_W'(1);
        r_d  <= d_c;
        r_dd <= SQ_W'(r_d) * SQ_W'(r_d);
        r_cc <= SQ_W'(r_c) * SQ_W'(r_c);

        case (r_state)
            ST_IDLE: begin
                r_pix      <= in_pix;
                r_wa       <= wa_c;
                r_wb       <= r_d - wa_c;
                r_wcur     <= wcur_c;
                r_wnext    <= r_d - wcur_c;
                r_tq       <= r_t;
                r_bank_cur <= r_bank;
                r_sh       <= '0;
                r_rd_col   <= in_dcol;
                r_rd_addr  <= (r_bank ? AW'(0) : AW'(MAX_DISPLAY_WIDTH)) + AW'(in_dcol);
                r_out_pix  <= '0;
                if (in_op == OP_READ) begin
                    r_show <= r_ready;
                end else begin
                    r_show <= r_ready || (in_le && rem_step >= (DISP_W+1)'(r_c));
                end
            end
            ST_PX_MUL1: r_prod1 <= 21'(r_pix) * 21'(wr_sel);
            ST_PX_MUL2: begin
                r_num <= NUM_W'(r_prod1) * NUM_W'(wc_sel);
                r_den <= DEN_W'(r_dd);
                r_q   <= '0;
                r_cnt <= 3'd7;
            end
            ST_PX_DIV, ST_RD_DIV: begin
                if (dge) begin
                    r_num      <= r_num - dsh;
                    r_q[r_cnt] <= 1'b1;
                end
                r_cnt <= r_cnt - 3'd1;
            end
            ST_PX_WR: r_sh <= r_sh + 2'd1;
            ST_RD_MUL: r_prod2 <= 41'(ram_rdata) * 41'(r_dd);
            ST_RD_SUM: begin
                r_num <= NUM_W'({r_prod2, 1'b0}) + NUM_W'(r_cc);
                r_den <= {r_cc, 1'b0};
                r_q   <= '0;
                r_cnt <= 3'd7;
            end
            ST_RD_SAT: r_sat <= r_num >= (NUM_W'(r_den) << 8);
            ST_RD_WR:  r_out_pix <= r_sat ? PIX_MAX : r_q;
            default:   r_cnt <= r_cnt;
        endcase

        if (m_load) begin
            r_m_data <= {(r_show ? r_idx - ROW_W'(1) : ROW_W'(0)), r_out_pix};
            r_m_user <= r_ready;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

// File: hdl/aald_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aald_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the area average line downscaler.
`timescale 1ns / 100ps

module tb_top;
    import aald_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic               op;
        logic [PIX_W-1:0]   pix;
        logic               line_end;
        logic [COORD_W-1:0] col;
    } req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             rdy;
        logic [ROW_W-1:0] row;
    } resp_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DISP_W-1:0]    i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;   // [7:0] pixel, [19:8] display_col, [23:20] 0
    logic                 s_axis_tlast = 1'b0; // line_end
    logic                 s_axis_tuser = 1'b0; // operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;        // [7:0] display_pixel, [23:8] display_row
    logic                 m_axis_tuser;        // row_ready

    area_average_line_downscaler dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow state of the downscaler
    logic [ACC_W-1:0] acc_mem [0:2*MAX_DISPLAY_WIDTH_DEF-1];
    int unsigned sh_col, sh_rem, sh_row, sh_bank;
    bit          sh_ready;
    int unsigned cfg_left = 0, cfg_right = 2047, cfg_width = 2048;

    req_t  pend_q[$];
    resp_t exp_q[$];
    req_t  drv_req;
    bit    in_fire = 1'b0;
    bit    no_gap = 1'b0;
    int    hold_req = 0, hold_seen = 0, hold_cnt = 0;
    int    errors = 0;
    int    n_pix = 0, n_rd = 0, n_rows = 0, n_cfg = 0;

    function automatic int unsigned crop_cols(int unsigned l, int unsigned r);
        return (r < l ? l : r) - l + 1;
    endfunction

    function automatic int unsigned disp_cols(int unsigned w, int unsigned c);
        int unsigned d;
        d = (w == 0) ? 1 : w;
        if (d > MAX_DISPLAY_WIDTH_DEF) d = MAX_DISPLAY_WIDTH_DEF;
        if (d > c) d = c;
        return d;
    endfunction

    function automatic void clear_shadow();
        foreach (acc_mem[k]) acc_mem[k] = '0;
        sh_col = 0; sh_rem = 0; sh_row = 0; sh_bank = 0; sh_ready = 0;
    endfunction

    function automatic void acc_add(int unsigned bank, longint unsigned col,
                                    int unsigned d, longint unsigned amt);
        longint unsigned s;
        int unsigned k;
        if (col >= d || amt == 0) return;
        k = bank * MAX_DISPLAY_WIDTH_DEF + int'(col);
        s = acc_mem[k] + amt;
        acc_mem[k] = (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic resp_t predict_downscale(req_t rq);
        resp_t r;
        int unsigned c, d, rem, bank_nx;
        longint unsigned i, t, wa, wb, wcur, wnext, dd, a, cc, v;
        bit show;
        c = crop_cols(cfg_left, cfg_right);
        d = disp_cols(cfg_width, c);
        r = '0;
        if (rq.op == OP_PIXEL) begin
            rem = sh_rem;
            if (sh_col < SCAN_WIDTH_DEF && sh_col >= cfg_left && sh_col - cfg_left < c
                && rq.pix != 0) begin
                i = sh_col - cfg_left;
                t = (i * d) / c;
                wa = (t + 1) * c - i * d;
                if (wa >= d) wa = d;
                wb = d - wa;
                wcur = (c - rem < d) ? c - rem : d;
                wnext = d - wcur;
                dd = longint'(d) * d;
                bank_nx = sh_bank ^ 1;
                acc_add(sh_bank, t, d, rq.pix * wcur * wa / dd);
                acc_add(sh_bank, t + 1, d, rq.pix * wcur * wb / dd);
                acc_add(bank_nx, t, d, rq.pix * wnext * wa / dd);
                acc_add(bank_nx, t + 1, d, rq.pix * wnext * wb / dd);
            end
            if (rq.line_end) begin
                sh_col = 0;
                if (rem + d >= c) begin
                    sh_ready = 1;
                    sh_bank ^= 1;
                    sh_row = (sh_row + 1) & 16'hFFFF;
                    sh_rem = rem + d - c;
                    n_rows++;
                end else begin
                    sh_rem = rem + d;
                end
            end else if (sh_col < SCAN_WIDTH_DEF) begin
                sh_col++;
            end
            show = sh_ready;
        end else begin
            show = sh_ready;
            if (sh_ready && rq.col < d) begin
                a = acc_mem[(sh_bank ^ 1) * MAX_DISPLAY_WIDTH_DEF + rq.col];
                cc = longint'(c) * c;
                v = (2 * a * d * d + cc) / (2 * cc);
                r.pix = (v > 255) ? PIX_MAX : v[7:0];
                acc_mem[(sh_bank ^ 1) * MAX_DISPLAY_WIDTH_DEF + rq.col] = '0;
                if (rq.col == d - 1) sh_ready = 0;
            end
        end
        r.rdy = sh_ready;
        r.row = show ? ROW_W'(sh_row - 1) : '0;
        return r;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_fire)) begin
            if (pend_q.size() > 0 && (no_gap || $urandom_range(99) >= 33)) begin
                drv_req = pend_q.pop_front();
                s_axis_tuser  <= drv_req.op;
                s_axis_tlast  <= drv_req.line_end;
                s_axis_tdata  <= {4'b0, drv_req.col, drv_req.pix};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // response receiver, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_cnt  = 600;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_gap || ($urandom_range(99) >= 33);
        end
    end

    // monitor: predict on accepted requests, check responses
    always @(posedge i_clk) begin
        resp_t want, got;
        req_t  rq;
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            rq.op = s_axis_tuser;
            rq.pix = s_axis_tdata[7:0];
            rq.col = s_axis_tdata[19:8];
            rq.line_end = s_axis_tlast;
            if (rq.op == OP_PIXEL) n_pix++; else n_rd++;
            exp_q.push_back(predict_downscale(rq));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pix = m_axis_tdata[7:0];
            got.row = m_axis_tdata[23:8];
            got.rdy = m_axis_tuser;
            if (exp_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response pix=%0d row=%0d rdy=%0b",
                                           got.pix, got.row, got.rdy);
            end else begin
                want = exp_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp pix=%0d row=%0d rdy=%0b, got pix=%0d row=%0d rdy=%0b",
                                 want.pix, want.row, want.rdy, got.pix, got.row, got.rdy);
                end
            end
        end
    end

    task automatic push_px(int p, bit le);
        req_t rq;
        rq.op = OP_PIXEL; rq.pix = p[7:0]; rq.line_end = le;
        rq.col = $urandom_range(4095);
        pend_q.push_back(rq);
    endtask

    task automatic push_rd(int col);
        req_t rq;
        rq.op = OP_READ; rq.pix = $urandom_range(255); rq.line_end = $urandom_range(1);
        rq.col = col[11:0];
        pend_q.push_back(rq);
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || s_axis_tvalid || exp_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[DISP_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_CROP_LEFT:     cfg_left  = val & 12'hFFF;
            CFG_CROP_RIGHT:    cfg_right = val & 12'hFFF;
            CFG_DISPLAY_WIDTH: cfg_width = val & 13'h1FFF;
            default: ;
        endcase
        if (idx == CFG_CROP_LEFT || idx == CFG_CROP_RIGHT || idx == CFG_DISPLAY_WIDTH)
            clear_shadow();
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic setup(int l, int r, int w);
        drain();
        write_reg(CFG_CROP_LEFT, l);
        write_reg(CFG_CROP_RIGHT, r);
        write_reg(CFG_DISPLAY_WIDTH, w);
    endtask

    // random lines; a row that the stream finishes is usually read back
    task automatic run_lines(int nlines);
        int unsigned c, d, rem, len;
        int p;
        c = crop_cols(cfg_left, cfg_right);
        d = disp_cols(cfg_width, c);
        rem = 0;
        repeat (nlines) begin
            len = cfg_left + c + $urandom_range(3);
            if (len > 48) len = 48;
            if ($urandom_range(9) == 0) len = $urandom_range(1, len);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(9))
                    0: p = 0;
                    1: p = 255;
                    default: p = $urandom_range(255);
                endcase
                push_px(p, k == len - 1);
            end
            if (rem + d >= c) begin
                rem = rem + d - c;
                if ($urandom_range(9) != 0) begin
                    for (int k = 0; k < d && k < 12; k++) push_rd(k);
                    if (d > 12) push_rd(d - 1);
                end
            end else begin
                rem = rem + d;
            end
            if ($urandom_range(9) == 0) push_rd($urandom_range(4095));
        end
    endtask

    initial begin
        clear_shadow();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults: full width, no downscale
        push_rd(0);                          // nothing ready yet, answered with zero
        push_px(255, 0); push_px(0, 0); push_px(1, 0); push_px(128, 1);
        push_rd(0); push_rd(1); push_rd(4095); push_rd(2047); push_rd(0);

        // small crop with outside columns on both sides
        setup(3, 12, 4);
        for (int k = 0; k < 16; k++) push_px(k == 5 ? 0 : 255, k == 15);
        for (int k = 0; k < 16; k++) push_px(255 - k, k == 15);
        for (int k = 0; k < 16; k++) push_px(k * 16, k == 15);
        push_rd(5); push_rd(0); push_rd(1); push_rd(2); push_rd(3);

        // receiver holds off while the sender keeps offering
        setup(3, 12, 4);
        run_lines(3);
        wait (s_axis_tready === 1'b1);       // RAM clear done
        hold_req++;
        drain();

        setup(0, 6, 7);      run_lines(2);
        setup(10, 5, 0);     run_lines(4);    // inverted crop, zero width
        setup(5, 40, 13);    run_lines(1);
        setup(2, 20, 3);     run_lines(1);
        setup(1, 30, 8191);  run_lines(1);    // width clipped to the crop
        setup(0, 15, 16);
        no_gap = 1'b1;
        run_lines(2);
        drain();
        no_gap = 1'b0;

        // widest crop and width: a few pixels only
        setup(0, 4095, 8191);
        repeat (20) push_px($urandom_range(255), 0);
        push_rd(0);
        push_px(7, 1);

        // crop beyond the scanned columns: nothing accumulates
        setup(4000, 4095, 96);
        for (int k = 0; k < 20; k++) push_px($urandom_range(1, 255), k == 19);
        push_rd(0);

        // 17 x 17 full pixels into one display pixel: the accumulator saturates
        setup(0, 16, 1);
        for (int k = 0; k < 289; k++) push_px(255, k % 17 == 16);
        push_rd(0); push_rd(0);

        // overrun of unread rows until the readout saturates
        setup(0, 0, 1);
        repeat (3) push_px(255, 1);
        push_rd(0); push_rd(0);
        drain();
        write_reg(CFG_UNUSED, 5);            // unused index, no effect
        push_px(9, 1); push_rd(0);

        setup(3, 12, 4);     run_lines(2);
        drain();

        $display("covered %0d pixel and %0d readout requests, %0d display rows, %0d register writes",
                 n_pix, n_rd, n_rows, n_cfg);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout with %0d responses outstanding", exp_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
